// ===== rtl/section_iv_table_engine_macros.svh =====
// Assertion macros used by the section IV table engine top level.
`ifndef SECTION_IV_TABLE_ENGINE_MACROS_SVH
`define SECTION_IV_TABLE_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIVT_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SIVT_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== rtl/sivt_pkg.sv =====
// Types and constants shared by the section IV table engine.
`default_nettype none

package sivt_pkg;

  localparam int KEY_WORDS  = 4;
  localparam int KEY_BYTES  = 32;
  localparam int SLOT_BITS  = 160;
  localparam int SLOT_WORDS = 5;
  localparam int WORD_BITS  = 32;
  localparam int CHUNK_BITS = 40;
  localparam int IV_BITS    = 64;

  localparam logic [1:0] OP_FILL = 2'd0;
  localparam logic [1:0] OP_HASH = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [1:0] LAST_CHUNK = 2'd3;

  localparam logic [2:0] REG_KEY0    = 3'd0;
  localparam logic [2:0] REG_KEY1    = 3'd1;
  localparam logic [2:0] REG_KEY2    = 3'd2;
  localparam logic [2:0] REG_KEY3    = 3'd3;
  localparam logic [2:0] REG_KEY_LEN = 3'd4;

  localparam logic [5:0] KEY_LEN_MAX   = 6'd32;
  localparam logic [5:0] KEY_LEN_RESET = 6'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_FILL
  } state_t;

  typedef struct packed {
    logic [KEY_WORDS-1:0][63:0] key_word;
    logic [5:0]                 key_length;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic fill_init;
    logic fill_write;
    logic hash_commit;
    logic read_commit;
  } cmd_t;

  typedef struct packed {
    logic fill_last;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/section_iv_table_engine.sv =====
// Top level of the section IV table engine.
//
// A request is taken on a rising edge with start high and busy low. A hash
// chunk or IV read request then holds busy in the HASH or READ state (one
// table RAM read, then the write-back or result capture); no new request is
// taken until it ends. A read result appears on out_iv_value with out_valid
// high for exactly one cycle, registered after the READ state; the receiver
// cannot stall it and must take it in that cycle. A fill request walks the
// table one slot per RAM write and holds busy until the last slot is written.
// Opcode 3 is taken without leaving the idle state and has no effect. The
// table holds no defined data until the first fill; reads or chunk updates
// before that return arbitrary values. The user must write configuration only
// while busy is low and no result is pending; the block does not enforce it.
`default_nettype none
`include "section_iv_table_engine_macros.svh"

module section_iv_table_engine #(
  parameter int SLOTS   = 800,
  parameter int STREAMS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [1:0]  in_stream_index,
  input  logic [1:0]  in_chunk_index,
  input  logic [39:0] in_chunk_data,
  output logic        out_valid,
  output logic [63:0] out_iv_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  sivt_pkg::cfg_t cfg;
  sivt_pkg::cmd_t cmd;
  sivt_pkg::sts_t sts;

  sivt_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sivt_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .opcode (in_opcode),
    .sts    (sts),
    .busy   (busy),
    .cmd    (cmd)
  );

  sivt_dp #(
    .SLOTS   (SLOTS),
    .STREAMS (STREAMS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg             (cfg),
    .in_opcode       (in_opcode),
    .in_stream_index (in_stream_index),
    .in_chunk_index  (in_chunk_index),
    .in_chunk_data   (in_chunk_data),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_iv_value    (out_iv_value)
  );

  `SIVT_ASSERT_IMP(a_result_while_idle, clk, rst_n, out_valid, !busy)
  `SIVT_ASSERT_NXT(a_strobe_single, clk, rst_n, out_valid, !out_valid)
  `SIVT_ASSERT_NXT(a_read_gives_result, clk, rst_n, cmd.read_commit, out_valid)
  `SIVT_ASSERT_NXT(a_fill_ends, clk, rst_n, cmd.fill_write && sts.fill_last, !busy)
  `SIVT_ASSERT_IMP(a_one_action, clk, rst_n, 1'b1,
                   $onehot0({cmd.capture, cmd.fill_write, cmd.hash_commit, cmd.read_commit}))

endmodule

`default_nettype wire

// ===== rtl/sivt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sivt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/sivt_regs.sv =====
// Configuration register file behind the APB-style port.
`default_nettype none

module sivt_regs (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [5:0]      paddr,
  input  logic [63:0]     pwdata,
  output logic [63:0]     prdata,
  output logic            pready,
  output sivt_pkg::cfg_t  cfg
);

  sivt_pkg::cfg_t cfg_r;
  sivt_pkg::cfg_t cfg_nxt;
  logic           wr_en;
  logic [2:0]     reg_idx;

  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        sivt_pkg::REG_KEY0:    cfg_nxt.key_word[0] = pwdata;
        sivt_pkg::REG_KEY1:    cfg_nxt.key_word[1] = pwdata;
        sivt_pkg::REG_KEY2:    cfg_nxt.key_word[2] = pwdata;
        sivt_pkg::REG_KEY3:    cfg_nxt.key_word[3] = pwdata;
        sivt_pkg::REG_KEY_LEN: cfg_nxt.key_length  = pwdata[5:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sivt_pkg::REG_KEY0:    prdata = cfg_r.key_word[0];
      sivt_pkg::REG_KEY1:    prdata = cfg_r.key_word[1];
      sivt_pkg::REG_KEY2:    prdata = cfg_r.key_word[2];
      sivt_pkg::REG_KEY3:    prdata = cfg_r.key_word[3];
      sivt_pkg::REG_KEY_LEN: prdata = 64'(cfg_r.key_length);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_word   <= '0;
      cfg_r.key_length <= sivt_pkg::KEY_LEN_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sivt_ctrl.sv =====
// Request sequencer: decodes requests and drives the datapath commands.
`default_nettype none

module sivt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [1:0]      opcode,
  input  sivt_pkg::sts_t  sts,
  output logic            busy,
  output sivt_pkg::cmd_t  cmd
);

  sivt_pkg::state_t state_r;
  sivt_pkg::state_t state_nxt;
  logic             accept;

  assign accept = start && (state_r == sivt_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sivt_pkg::ST_IDLE: begin
        if (accept) begin
          case (opcode)
            sivt_pkg::OP_FILL: state_nxt = sivt_pkg::ST_FILL;
            sivt_pkg::OP_HASH: state_nxt = sivt_pkg::ST_HASH;
            sivt_pkg::OP_READ: state_nxt = sivt_pkg::ST_READ;
            default:           state_nxt = sivt_pkg::ST_IDLE;
          endcase
        end
      end
      sivt_pkg::ST_HASH: state_nxt = sivt_pkg::ST_IDLE;
      sivt_pkg::ST_READ: state_nxt = sivt_pkg::ST_IDLE;
      sivt_pkg::ST_FILL: begin
        if (sts.fill_last) begin
          state_nxt = sivt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sivt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      sivt_pkg::ST_IDLE: begin
        busy          = 1'b0;
        cmd.capture   = accept;
        cmd.fill_init = accept && (opcode == sivt_pkg::OP_FILL);
      end
      sivt_pkg::ST_HASH: cmd.hash_commit = 1'b1;
      sivt_pkg::ST_READ: cmd.read_commit = 1'b1;
      sivt_pkg::ST_FILL: cmd.fill_write  = 1'b1;
      default: begin
        cmd  = '0;
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sivt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sivt_dp.sv =====
// Datapath: use counters, slot addressing, fill generator, table RAM and result register.
`default_nettype none

module sivt_dp #(
  parameter int SLOTS   = 800,
  parameter int STREAMS = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sivt_pkg::cmd_t                cmd,
  input  sivt_pkg::cfg_t                cfg,
  input  logic [1:0]                    in_opcode,
  input  logic [1:0]                    in_stream_index,
  input  logic [1:0]                    in_chunk_index,
  input  logic [39:0]                   in_chunk_data,
  output sivt_pkg::sts_t                sts,
  output logic                          out_valid,
  output logic [sivt_pkg::IV_BITS-1:0]  out_iv_value
);

  localparam int PERIOD_RAW = SLOTS / STREAMS;
  localparam int PERIOD     = (PERIOD_RAW == 0) ? 1 : PERIOD_RAW;
  localparam int CW         = (PERIOD > 1) ? $clog2(PERIOD) : 1;
  localparam int AW         = $clog2(SLOTS);
  localparam int SW         = (STREAMS > 1) ? $clog2(STREAMS) : 1;

  localparam logic [CW-1:0] CNT_RESET  = CW'(1 % PERIOD);
  localparam logic [CW-1:0] CNT_LAST   = CW'(PERIOD - 1);
  localparam logic [AW-1:0] STREAMS_A  = AW'(STREAMS);
  localparam logic [AW-1:0] SLOT_LAST  = AW'(SLOTS - 1);

  function automatic logic [SW-1:0] reduce_stream(input logic [1:0] idx);
    logic [4:0] s;
    s = {3'b000, idx};
    for (int k = 0; k < 3; k++) begin
      if (int'(s) >= STREAMS) begin
        s = s - 5'(STREAMS);
      end
    end
    return SW'(s);
  endfunction

  function automatic logic [4:0] key_step(input logic [4:0] p, input logic [5:0] len);
    logic [5:0] q;
    q = {1'b0, p} + 6'd1;
    return (q == len) ? 5'd0 : q[4:0];
  endfunction

  logic [CW-1:0] cnt_r   [STREAMS];
  logic [CW-1:0] cnt_nxt [STREAMS];
  logic [AW-1:0] fill_ptr_r;
  logic [AW-1:0] fill_ptr_nxt;
  logic [4:0]    key_pos_r;
  logic [4:0]    key_pos_nxt;
  logic          out_valid_r;
  logic          out_valid_nxt;

  logic [SW-1:0]                    stream_r;
  logic [1:0]                       chunk_r;
  logic [39:0]                      data_r;
  logic [AW-1:0]                    slot_r;
  logic [sivt_pkg::IV_BITS-1:0]     out_iv_r;

  logic [SW-1:0]                    stream_sel;
  logic [CW-1:0]                    cnt_cur;
  logic [CW-1:0]                    cnt_prev;
  logic [CW-1:0]                    cnt_use;
  logic [CW-1:0]                    cnt_hash;
  logic [AW-1:0]                    slot_sel;

  logic [5:0]                       key_len;
  logic [sivt_pkg::KEY_BYTES*8-1:0] key_flat;
  logic [4:0]                       pos [sivt_pkg::SLOT_WORDS+1];
  logic [sivt_pkg::SLOT_BITS-1:0]   fill_slot;
  logic [sivt_pkg::SLOT_BITS-1:0]   hash_mask;

  logic                             ram_we;
  logic [AW-1:0]                    ram_waddr;
  logic [sivt_pkg::SLOT_BITS-1:0]   ram_wdata;
  logic [sivt_pkg::SLOT_BITS-1:0]   ram_rdata;

  assign stream_sel = reduce_stream(in_stream_index);
  assign cnt_cur    = cnt_r[stream_sel];
  assign cnt_prev   = (cnt_cur == '0) ? CNT_LAST : cnt_cur - 1'b1;
  assign cnt_use    = (in_opcode == sivt_pkg::OP_READ) ? cnt_prev : cnt_cur;
  assign slot_sel   = AW'(stream_sel) + STREAMS_A * AW'(cnt_use);

  assign key_len  = (cfg.key_length > sivt_pkg::KEY_LEN_MAX) ? sivt_pkg::KEY_LEN_MAX
                                                             : cfg.key_length;
  assign key_flat = cfg.key_word;

  always_comb begin
    pos[0] = key_pos_r;
    for (int q = 1; q <= sivt_pkg::SLOT_WORDS; q++) begin
      pos[q] = key_step(pos[q-1], key_len);
    end
    for (int q = 0; q < sivt_pkg::SLOT_WORDS; q++) begin
      fill_slot[q*sivt_pkg::WORD_BITS +: sivt_pkg::WORD_BITS] =
        (key_len == 6'd0) ? '0 : {4{key_flat[pos[q]*8 +: 8]}};
    end
  end

  assign hash_mask = sivt_pkg::SLOT_BITS'(data_r) << (sivt_pkg::CHUNK_BITS * int'(chunk_r));
  assign cnt_hash  = cnt_r[stream_r];

  always_comb begin
    cnt_nxt       = cnt_r;
    fill_ptr_nxt  = fill_ptr_r;
    key_pos_nxt   = key_pos_r;
    out_valid_nxt = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = slot_r;
    ram_wdata     = ram_rdata ^ hash_mask;
    if (cmd.fill_init) begin
      fill_ptr_nxt = '0;
      key_pos_nxt  = '0;
      for (int s = 0; s < STREAMS; s++) begin
        cnt_nxt[s] = CNT_RESET;
      end
    end
    if (cmd.fill_write) begin
      ram_we       = 1'b1;
      ram_waddr    = fill_ptr_r;
      ram_wdata    = fill_slot;
      fill_ptr_nxt = fill_ptr_r + 1'b1;
      key_pos_nxt  = pos[sivt_pkg::SLOT_WORDS];
    end
    if (cmd.hash_commit) begin
      ram_we = 1'b1;
      if (chunk_r == sivt_pkg::LAST_CHUNK) begin
        cnt_nxt[stream_r] = (cnt_hash == CNT_LAST) ? '0 : cnt_hash + 1'b1;
      end
    end
    if (cmd.read_commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign sts.fill_last = (fill_ptr_r == SLOT_LAST);
  assign out_valid     = out_valid_r;
  assign out_iv_value  = out_iv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < STREAMS; s++) begin
        cnt_r[s] <= CNT_RESET;
      end
      fill_ptr_r  <= '0;
      key_pos_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      fill_ptr_r  <= fill_ptr_nxt;
      key_pos_r   <= key_pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      stream_r <= stream_sel;
      chunk_r  <= in_chunk_index;
      data_r   <= in_chunk_data;
      slot_r   <= slot_sel;
    end
    if (cmd.read_commit) begin
      out_iv_r <= ram_rdata[sivt_pkg::IV_BITS-1:0];
    end
  end

  sivt_ram #(
    .WIDTH (sivt_pkg::SLOT_BITS),
    .DEPTH (SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.capture),
    .raddr (slot_sel),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the section IV table engine: fill, hash chunk and IV read requests.
`default_nettype none

module tb;

  localparam int SLOTS       = 800;
  localparam int STREAMS     = 4;
  localparam int SLOT_BYTES  = 20;
  localparam int CHUNK_BYTES = 5;
  localparam int PERIOD      = (SLOTS / STREAMS) == 0 ? 1 : SLOTS / STREAMS;
  localparam int ITEMS       = 1950;
  localparam int PHASES      = 6;
  localparam int IDLE_LIMIT  = 4 * SLOTS + 1000;

  localparam logic [1:0] OP_NONE = 2'd3;

  class iv_scoreboard;
    byte unsigned slot_bytes [SLOTS*SLOT_BYTES];
    int           use_count [STREAMS];
    logic [63:0]  key_word [sivt_pkg::KEY_WORDS];
    logic [5:0]   key_len;
    logic [63:0]  iv_due [$];
    int           errors;

    function new();
      foreach (use_count[i]) use_count[i] = 1 % PERIOD;
      foreach (key_word[i]) key_word[i] = '0;
      key_len = sivt_pkg::KEY_LEN_RESET;
      errors  = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] val);
      if (idx <= sivt_pkg::REG_KEY3) key_word[idx] = val;
      else if (idx == sivt_pkg::REG_KEY_LEN) key_len = val[5:0];
    endfunction

    function byte unsigned key_byte(int n);
      return key_word[(n >> 3) & 3][8*(n & 7) +: 8];
    endfunction

    function void note_request(logic [1:0] op, logic [1:0] stream, logic [1:0] chunk,
                               logic [39:0] data);
      int          s;
      int          len;
      int          base;
      int          prev;
      logic [63:0] v;
      s = int'(stream) % STREAMS;
      case (op)
        sivt_pkg::OP_FILL: begin
          len = int'(key_len > sivt_pkg::KEY_LEN_MAX ? sivt_pkg::KEY_LEN_MAX : key_len);
          foreach (slot_bytes[j]) slot_bytes[j] = len == 0 ? 8'h00 : key_byte((j / 4) % len);
          foreach (use_count[i]) use_count[i] = 1 % PERIOD;
        end
        sivt_pkg::OP_HASH: begin
          base = ((s + STREAMS * use_count[s]) % SLOTS) * SLOT_BYTES
                 + int'(chunk) * CHUNK_BYTES;
          for (int x = 0; x < CHUNK_BYTES; x++) slot_bytes[base+x] ^= data[8*x +: 8];
          if (chunk == sivt_pkg::LAST_CHUNK) use_count[s] = (use_count[s] + 1) % PERIOD;
        end
        sivt_pkg::OP_READ: begin
          prev = (use_count[s] + PERIOD - 1) % PERIOD;
          base = ((s + STREAMS * prev) % SLOTS) * SLOT_BYTES;
          v = '0;
          for (int x = 0; x < 8; x++) v[8*x +: 8] = slot_bytes[base+x];
          iv_due.push_back(v);
        end
        default: ;
      endcase
    endfunction

    function void check_iv(logic [63:0] got);
      logic [63:0] want;
      if (iv_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected iv result, expected none, got %h", $time, got);
      end else begin
        want = iv_due.pop_front();
        if (want !== got) begin
          errors++;
          $display("%0t: iv mismatch, expected %h, got %h", $time, want, got);
        end
      end
    endfunction

    function int pending();
      return iv_due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_opcode;
  logic [1:0]  in_stream_index;
  logic [1:0]  in_chunk_index;
  logic [39:0] in_chunk_data;
  logic        out_valid;
  logic [63:0] out_iv_value;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  iv_scoreboard sb;
  int           requests_sent;
  int           idle_cycles;
  bit           gaps_on;

  section_iv_table_engine #(.SLOTS(SLOTS), .STREAMS(STREAMS)) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_stream_index (in_stream_index),
    .in_chunk_index  (in_chunk_index),
    .in_chunk_data   (in_chunk_data),
    .out_valid       (out_valid),
    .out_iv_value    (out_iv_value),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_iv(out_iv_value);
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [39:0] rand40();
    return 40'({$urandom, $urandom});
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send(logic [1:0] op, logic [1:0] stream, logic [1:0] chunk, logic [39:0] data);
    if (gaps_on && $urandom_range(99) < 14) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start           <= 1'b1;
    in_opcode       <= op;
    in_stream_index <= stream;
    in_chunk_index  <= chunk;
    in_chunk_data   <= data;
    do @(posedge clk); while (busy);
    sb.note_request(op, stream, chunk, data);
    if (op != OP_NONE) requests_sent++;
  endtask

  // hold start low until the block is idle and every IV has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (busy || sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic load_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2, logic [63:0] k3,
                          logic [5:0] len);
    drain();
    cfg_write(sivt_pkg::REG_KEY0, k0);
    cfg_write(sivt_pkg::REG_KEY1, k1);
    cfg_write(sivt_pkg::REG_KEY2, k2);
    cfg_write(sivt_pkg::REG_KEY3, k3);
    cfg_write(sivt_pkg::REG_KEY_LEN, {58'd0, len});
  endtask

  // advance one stream through a full counter period, reading around the wrap
  task automatic wrap_stream();
    logic [1:0] s;
    s = 2'($urandom_range(0, 3));
    send(sivt_pkg::OP_FILL, s, 2'd0, rand40());
    for (int k = 0; k < PERIOD + 2; k++) begin
      send(sivt_pkg::OP_HASH, s, sivt_pkg::LAST_CHUNK, rand40());
      if (k >= PERIOD - 4) send(sivt_pkg::OP_READ, s, 2'($urandom_range(0, 3)), rand40());
    end
  endtask

  task automatic run_requests(int target);
    int         r;
    logic [1:0] s;
    send(sivt_pkg::OP_FILL, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), rand40());
    while (requests_sent < target) begin
      r = $urandom_range(99);
      s = 2'($urandom_range(0, 3));
      if (r < 70) begin
        for (int c = 0; c < 4; c++) send(sivt_pkg::OP_HASH, s, 2'(c), rand40());
        if ($urandom_range(9) != 0) begin
          send(sivt_pkg::OP_READ, s, 2'($urandom_range(0, 3)), rand40());
        end
      end else if (r < 80) begin
        send(sivt_pkg::OP_READ, s, 2'($urandom_range(0, 3)), rand40());
      end else if (r < 97) begin
        send(2'($urandom_range(1, 3)), s, 2'($urandom_range(0, 3)), rand40());
      end else begin
        send(sivt_pkg::OP_FILL, s, 2'($urandom_range(0, 3)), rand40());
      end
    end
  endtask

  initial begin
    sb              = new();
    clk             = 1'b0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_opcode       = sivt_pkg::OP_FILL;
    in_stream_index = '0;
    in_chunk_index  = '0;
    in_chunk_data   = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    idle_cycles     = 0;
    requests_sent   = 0;
    gaps_on         = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_key(rand64(), rand64(), rand64(), rand64(), sivt_pkg::KEY_LEN_MAX);
    send(sivt_pkg::OP_FILL, 2'd0, 2'd0, 40'd0);
    send(sivt_pkg::OP_READ, 2'd0, 2'd0, 40'd0);
    send(sivt_pkg::OP_HASH, 2'd0, 2'd0, '1);
    send(sivt_pkg::OP_HASH, 2'd0, 2'd1, '0);
    send(sivt_pkg::OP_HASH, 2'd0, 2'd2, rand40());
    send(sivt_pkg::OP_HASH, 2'd0, sivt_pkg::LAST_CHUNK, '1);
    send(sivt_pkg::OP_READ, 2'd0, 2'd0, 40'd0);
    send(sivt_pkg::OP_READ, 2'd3, 2'd3, '1);
    send(OP_NONE, 2'd3, 2'd3, '1);
    send(OP_NONE, 2'd0, 2'd0, '0);
    send(sivt_pkg::OP_HASH, 2'd3, sivt_pkg::LAST_CHUNK, rand40());
    send(sivt_pkg::OP_READ, 2'd3, 2'd0, 40'd0);
    send(sivt_pkg::OP_HASH, 2'd2, 2'd1, rand40());
    send(sivt_pkg::OP_READ, 2'd2, 2'd2, rand40());
    send(sivt_pkg::OP_HASH, 2'd1, 2'd0, rand40());
    send(sivt_pkg::OP_HASH, 2'd1, sivt_pkg::LAST_CHUNK, rand40());
    send(sivt_pkg::OP_READ, 2'd1, 2'd1, rand40());
    send(sivt_pkg::OP_FILL, 2'd2, 2'd1, rand40());
    send(sivt_pkg::OP_READ, 2'd0, 2'd3, rand40());

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: load_key(rand64(), rand64(), rand64(), rand64(), 6'd1);
        1: load_key(rand64(), rand64(), rand64(), rand64(), sivt_pkg::KEY_LEN_MAX);
        2: load_key(rand64(), rand64(), rand64(), rand64(), 6'd0);
        3: load_key('1, '1, '1, '1, 6'd63);
        4: load_key('0, '0, '0, '0, 6'($urandom_range(1, 32)));
        default: load_key(rand64(), rand64(), rand64(), rand64(), 6'($urandom_range(1, 32)));
      endcase
      gaps_on = (p != 1);
      if (p == 1) wrap_stream();
      run_requests(ITEMS * (p + 1) / PHASES);
    end

    start <= 1'b0;
    @(posedge clk);
    while (busy || sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== section_iv_table_engine.f =====
+incdir+rtl
rtl/sivt_pkg.sv
rtl/sivt_ram.sv
rtl/sivt_regs.sv
rtl/sivt_ctrl.sv
rtl/sivt_dp.sv
rtl/section_iv_table_engine.sv
test/tb.sv
